/* hw/rtl/dptt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dptt_pkg
// Shared types and constants for the depth-preferred transposition table.
// ----------------------------------------------------------------------------
package dptt_pkg;

    typedef enum logic [1:0] {
        FUNC_PROBE = 2'd0,
        FUNC_STORE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_USAGE = 2'd3
    } func_t;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 32;
    localparam int SCORE_W  = 16;
    localparam int DEPTH_W  = 16;
    localparam int FLAG_W   = 2;
    localparam int MOVE_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int USAGE_W  = 17;

    // s_tdata: key_hash, value_centi, search_depth, bound_flag, move_code
    localparam int IN_KEY_LSB   = 0;
    localparam int IN_VALUE_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_DEPTH_LSB = IN_VALUE_LSB + VALUE_W;
    localparam int IN_FLAG_LSB  = IN_DEPTH_LSB + DEPTH_W;
    localparam int IN_MOVE_LSB  = IN_FLAG_LSB + FLAG_W;
    localparam int IN_FIELDS_W  = IN_MOVE_LSB + MOVE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // s_tuser: func, move_present
    localparam int IN_PRESENT_BIT = FUNC_W;
    localparam int IN_TUSER_W     = FUNC_W + 1;

    // m_tdata: value_out, depth_out, flag_out, move_out, usage_estimate
    localparam int OUT_FIELDS_W = SCORE_W + DEPTH_W + FLAG_W + MOVE_W + USAGE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // m_tuser: hit
    localparam int OUT_TUSER_W = 1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 16'h7FFF;
    localparam logic [SCORE_W-1:0] SCORE_MIN = 16'h8000;

    localparam int SAMPLE_COUNT  = 1000;
    localparam int SAMPLE_STRIDE = 1000;
    localparam int SCALE_DIV     = 1000;
    localparam int COUNT_W       = 10;

    // p / 1000 == (p * RECIP_1000) >> RECIP_SHIFT for any p below 2**27
    localparam int RECIP_W      = 28;
    localparam int RECIP_SHIFT  = 37;
    localparam int RECIP_PROD_W = RECIP_SHIFT + USAGE_W;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 28'd137438954;

    typedef struct packed {
        logic [MOVE_W-1:0]  move;
        logic [FLAG_W-1:0]  flag;
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
    } slot_t;

    typedef struct packed {
        logic capture;
        logic sweep_start;
        logic sweep_write;
        logic lookup;
        logic usage_start;
        logic usage_read;
        logic scale;
        logic div_step;
        logic load_result;
        logic result_usage;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic sample_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/dptt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dptt_datapath
// Slot memory, item capture, replacement check, occupancy sampler, scaling
// divider and output register.
// ----------------------------------------------------------------------------
module dptt_datapath #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dptt_pkg::dp_cmd_t                cmd,
    output dptt_pkg::dp_status_t             status,
    input  logic [dptt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [dptt_pkg::IN_TUSER_W-1:0]  s_tuser,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [dptt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [dptt_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import dptt_pkg::*;

    localparam int ADDR_W     = $clog2(TABLE_ENTRIES);
    localparam int NUM_W      = $clog2(TABLE_ENTRIES + 1);
    localparam int PROD_W     = COUNT_W + NUM_W;
    localparam logic [ADDR_W-1:0] SLOT_MASK = ADDR_W'(TABLE_ENTRIES - 1);

    slot_t mem [TABLE_ENTRIES];
    slot_t rd_slot_reg;
    slot_t wr_data;
    logic  wr_en;
    logic  rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic [KEY_W-1:0]   in_key;
    logic [VALUE_W-1:0] in_value;
    logic [SCORE_W-1:0] in_score;
    logic [ADDR_W-1:0]  in_idx;

    func_t              func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [FLAG_W-1:0]  flag_reg;
    logic [MOVE_W-1:0]  move_reg;
    logic               present_reg;
    logic [ADDR_W-1:0]  idx_reg;

    logic [ADDR_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [COUNT_W-1:0] sample_cnt_reg, sample_cnt_next;
    logic [ADDR_W-1:0]  sample_acc_reg, sample_acc_next;
    logic               sample_pend_reg;
    logic [COUNT_W-1:0] used_reg, used_next;

    logic [PROD_W-1:0]       prod_reg;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [USAGE_W-1:0]      quo_reg;

    logic               key_match;
    logic               take;
    logic               hit;
    logic               out_load;
    logic               out_valid_reg;
    logic               hit_reg;
    logic [SCORE_W-1:0] out_value_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    logic [FLAG_W-1:0]  out_flag_reg;
    logic [MOVE_W-1:0]  out_move_reg;
    logic [USAGE_W-1:0] out_usage_reg;

    // item decode and score saturation
    assign in_key   = s_tdata[IN_KEY_LSB +: KEY_W];
    assign in_value = s_tdata[IN_VALUE_LSB +: VALUE_W];
    assign in_idx   = in_key[ADDR_W-1:0] & SLOT_MASK;

    always_comb
    begin
        if (in_value[VALUE_W-1:SCORE_W-1] == {(VALUE_W-SCORE_W+1){in_value[VALUE_W-1]}})
        begin
            in_score = in_value[SCORE_W-1:0];
        end
        else if (in_value[VALUE_W-1])
        begin
            in_score = SCORE_MIN;
        end
        else
        begin
            in_score = SCORE_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= func_t'(s_tuser[FUNC_W-1:0]);
            key_reg     <= in_key;
            score_reg   <= in_score;
            depth_reg   <= s_tdata[IN_DEPTH_LSB +: DEPTH_W];
            flag_reg    <= s_tdata[IN_FLAG_LSB +: FLAG_W];
            move_reg    <= s_tdata[IN_MOVE_LSB +: MOVE_W];
            present_reg <= s_tuser[IN_PRESENT_BIT];
            idx_reg     <= in_idx;
        end
    end

    // replacement check on the slot read at capture
    assign key_match = (rd_slot_reg.key == key_reg);
    assign take      = (func_reg == FUNC_STORE) &&
                       ((rd_slot_reg.key == '0) || key_match ||
                        (rd_slot_reg.depth < depth_reg));
    assign hit       = (func_reg == FUNC_PROBE) && key_match;

    // memory ports
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        if (cmd.sweep_write)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_reg;
        end
        else if (cmd.lookup && take)
        begin
            wr_en         = 1'b1;
            wr_data.key   = key_reg;
            wr_data.score = score_reg;
            wr_data.depth = depth_reg;
            wr_data.flag  = flag_reg;
            wr_data.move  = present_reg ? move_reg : rd_slot_reg.move;
        end
    end

    assign rd_en   = cmd.capture || cmd.usage_read;
    assign rd_addr = cmd.capture ? in_idx : (sample_acc_reg & SLOT_MASK);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_slot_reg <= mem[rd_addr];
        end
    end

    // sweep and sampling counters
    always_comb
    begin
        sweep_cnt_next = sweep_cnt_reg;
        if (cmd.sweep_start)
        begin
            sweep_cnt_next = '0;
        end
        else if (cmd.sweep_write)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
        end

        sample_cnt_next = sample_cnt_reg;
        sample_acc_next = sample_acc_reg;
        used_next       = used_reg;
        if (cmd.usage_start)
        begin
            sample_cnt_next = '0;
            sample_acc_next = '0;
            used_next       = '0;
        end
        else
        begin
            if (cmd.usage_read)
            begin
                sample_cnt_next = sample_cnt_reg + 1'b1;
                sample_acc_next = sample_acc_reg + ADDR_W'(SAMPLE_STRIDE);
            end
            if (sample_pend_reg && (rd_slot_reg.key != '0))
            begin
                used_next = used_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg   <= '0;
            sample_cnt_reg  <= '0;
            sample_acc_reg  <= '0;
            sample_pend_reg <= 1'b0;
            used_reg        <= '0;
        end
        else
        begin
            sweep_cnt_reg   <= sweep_cnt_next;
            sample_cnt_reg  <= sample_cnt_next;
            sample_acc_reg  <= sample_acc_next;
            sample_pend_reg <= cmd.usage_read;
            used_reg        <= used_next;
        end
    end

    // count * entries / 1000: scale into prod_reg, reciprocal multiply in the next cycle
    assign recip_prod = RECIP_PROD_W'(prod_reg) * RECIP_PROD_W'(RECIP_1000);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            prod_reg <= PROD_W'(used_reg) * PROD_W'(TABLE_ENTRIES);
        end
        if (cmd.div_step)
        begin
            quo_reg <= recip_prod[RECIP_SHIFT +: USAGE_W];
        end
    end

    // output register
    assign out_load = cmd.lookup || cmd.load_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hit_reg       <= cmd.lookup && hit;
            out_value_reg <= (cmd.lookup && hit) ? rd_slot_reg.score : '0;
            out_depth_reg <= (cmd.lookup && hit) ? rd_slot_reg.depth : '0;
            out_flag_reg  <= (cmd.lookup && hit) ? rd_slot_reg.flag  : '0;
            out_move_reg  <= (cmd.lookup && hit) ? rd_slot_reg.move  : '0;
            out_usage_reg <= (cmd.load_result && cmd.result_usage) ? quo_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_usage_reg, out_move_reg, out_flag_reg,
                       out_depth_reg, out_value_reg};

    assign status.sweep_last  = (sweep_cnt_reg == SLOT_MASK);
    assign status.sample_last = (sample_cnt_reg == COUNT_W'(SAMPLE_COUNT - 1));
    assign status.out_free    = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

/* hw/rtl/dptt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dptt_ctrl
// Sequencer: transaction acceptance, lookup, table sweep, sampling and
// scaling, result hand-off.
// ----------------------------------------------------------------------------
module dptt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dptt_pkg::func_t      func,
    input  dptt_pkg::dp_status_t status,
    output dptt_pkg::dp_cmd_t    cmd
);
    import dptt_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE        = 8'b0000_0001,
        ST_SWEEP       = 8'b0000_0010,
        ST_LOOKUP      = 8'b0000_0100,
        ST_SAMPLE      = 8'b0000_1000,
        ST_SAMPLE_TAIL = 8'b0001_0000,
        ST_SCALE       = 8'b0010_0000,
        ST_DIVIDE      = 8'b0100_0000,
        ST_EMIT        = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   sweep_emit_reg, sweep_emit_next;
    logic   emit_usage_reg, emit_usage_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        sweep_emit_next = sweep_emit_reg;
        emit_usage_next = emit_usage_reg;
        cmd             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    unique case (func)
                        FUNC_PROBE, FUNC_STORE:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        FUNC_CLEAR:
                        begin
                            cmd.sweep_start = 1'b1;
                            sweep_emit_next = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        FUNC_USAGE:
                        begin
                            cmd.usage_start = 1'b1;
                            state_next      = ST_SAMPLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (status.sweep_last)
                begin
                    emit_usage_next = 1'b0;
                    state_next      = sweep_emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                if (status.out_free)
                begin
                    cmd.lookup = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SAMPLE:
            begin
                cmd.usage_read = 1'b1;
                if (status.sample_last)
                begin
                    state_next = ST_SAMPLE_TAIL;
                end
            end
            ST_SAMPLE_TAIL:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step    = 1'b1;
                emit_usage_next = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result  = 1'b1;
                    cmd.result_usage = emit_usage_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset starts with a zeroing sweep that produces no transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_emit_reg <= 1'b0;
            emit_usage_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_emit_reg <= sweep_emit_next;
            emit_usage_reg <= emit_usage_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/depth_preferred_transposition_table_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// depth_preferred_transposition_table_core
// Direct-mapped transposition table with depth-preferred replacement,
// table clear and sampled occupancy estimate.
// ----------------------------------------------------------------------------
// Channel  Dir  Carries
// s_*      in   operation request (func, hash, score, depth, bound, move)
// m_*      out  one result per request (hit, score, depth, bound, move, usage)
//
// Probe/store: one registered slot read, then compare and write.
// Clear: one slot zeroed per cycle on the write port.
// Usage: accept, 1000 sampled reads, last-read drain, scale, reciprocal
// divide and result load.
// After reset a zeroing sweep of all TABLE_ENTRIES slots runs with s_tready low.
// A stalled m_* holds the result; the lookup waits until the register frees.
// ----------------------------------------------------------------------------
module depth_preferred_transposition_table_core #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_hash[63:0], value_centi[95:64], search_depth[111:96],
    // bound_flag[113:112], move_code[145:114], zero fill
    input  logic [dptt_pkg::IN_TDATA_W-1:0]  s_tdata,
    // func[1:0], move_present[2]
    input  logic [dptt_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // value_out[15:0], depth_out[31:16], flag_out[33:32], move_out[65:34],
    // usage_estimate[82:66], zero fill
    output logic [dptt_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit[0]
    output logic [dptt_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import dptt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    func_t      func;

    assign func = func_t'(s_tuser[FUNC_W-1:0]);

    dptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    dptt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
